// File: rtl/core/ptb_pkg.sv
// Shared types and constants for the periodic timer bank.
`default_nettype none

package ptb_pkg;

    // Default number of timers in the bank
    localparam int NUM_TIMERS_DEF = 8;

    // Field widths of the input and result words
    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 3;
    localparam int INTERVAL_W = 16;
    localparam int MASK_W     = 8;

    // Action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_ASSIGN  = 2'd1,
        ACT_ENABLE  = 2'd2,
        ACT_DISABLE = 2'd3
    } action_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/periodic_timer_bank.sv
// Periodic timer bank: timer counts and intervals in memories, walked once per tick.
// Assign, enable and disable words take effect in the accept cycle and give no result.
// A tick word raises its fire mask after one read-modify-write of the count memory per timer,
// ST_FINISH to drain the last write and ST_EMIT to load the result, later while the output
// word is stalled. A tick holds off new words until its result is loaded; otherwise one other
// word is taken every cycle. Reset clears flags, sequencer and result register.
`default_nettype none

module periodic_timer_bank #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [ptb_pkg::ACTION_W-1:0]   action,
    input  wire logic [ptb_pkg::INDEX_W-1:0]    timer_index,
    input  wire logic [ptb_pkg::INTERVAL_W-1:0] reload_interval,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [ptb_pkg::MASK_W-1:0]          fire_mask
);

    import ptb_pkg::*;

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int WIDE_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    // Timer state memories
    logic [INTERVAL_W-1:0] cnt_mem [NUM_TIMERS];
    logic [INTERVAL_W-1:0] per_mem [NUM_TIMERS];
    logic [INTERVAL_W-1:0] cnt_rd_reg;
    logic [INTERVAL_W-1:0] per_rd_reg;

    // Control registers
    state_t                state_reg,     state_next;
    logic [IDX_W-1:0]      ptr_reg,       ptr_next;
    logic                  s1_valid_reg,  s1_valid_next;
    logic [IDX_W-1:0]      s1_idx_reg,    s1_idx_next;
    logic [MASK_W-1:0]     mask_reg,      mask_next;
    logic                  out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]     fire_mask_reg, fire_mask_next;
    logic [NUM_TIMERS-1:0] run_reg,       run_next;
    logic [NUM_TIMERS-1:0] asg_reg,       asg_next;

    // Memory write port controls
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_wa;
    logic [INTERVAL_W-1:0] cnt_wd;
    logic                  per_we;

    // Addressed timer, widened then cut to the memory index width
    logic [WIDE_W-1:0]     sel_wide;
    logic [IDX_W-1:0]      sel_idx;
    logic                  sel_in_range;

    assign sel_wide     = WIDE_W'(timer_index);
    assign sel_idx      = sel_wide[IDX_W-1:0];
    assign sel_in_range = int'(timer_index) < NUM_TIMERS;

    // Drive ports
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign fire_mask = fire_mask_reg;

    // Write and read the timer memories
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (per_we)
        begin
            per_mem[sel_idx] <= reload_interval;
        end
        cnt_rd_reg <= cnt_mem[ptr_reg];
        per_rd_reg <= per_mem[ptr_reg];
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_idx_reg    <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            fire_mask_reg <= '0;
            run_reg       <= '0;
            asg_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            s1_valid_reg  <= s1_valid_next;
            s1_idx_reg    <= s1_idx_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            fire_mask_reg <= fire_mask_next;
            run_reg       <= run_next;
            asg_reg       <= asg_next;
        end
    end

    // Sequence commands and the tick walk
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        s1_valid_next  = 1'b0;
        s1_idx_next    = ptr_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg & out_stall;
        fire_mask_next = fire_mask_reg;
        run_next       = run_reg;
        asg_next       = asg_reg;
        cnt_we         = 1'b0;
        cnt_wa         = sel_idx;
        cnt_wd         = '0;
        per_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_TICK)
                    begin
                        state_next = ST_SCAN;
                        ptr_next   = '0;
                        mask_next  = '0;
                    end
                    else if (sel_in_range)
                    begin
                        case (action)
                            ACT_ASSIGN:
                            begin
                                per_we            = 1'b1;
                                cnt_we            = 1'b1;
                                run_next[sel_idx] = 1'b1;
                                asg_next[sel_idx] = 1'b1;
                            end
                            ACT_ENABLE:
                            begin
                                cnt_we            = 1'b1;
                                run_next[sel_idx] = 1'b1;
                            end
                            ACT_DISABLE:
                            begin
                                run_next[sel_idx] = 1'b0;
                            end
                            default:
                            begin
                                cnt_we = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue one read per timer
                s1_valid_next = 1'b1;
                s1_idx_next   = ptr_reg;
                if (ptr_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    fire_mask_next = mask_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance or reload the timer read in the previous cycle
        if (s1_valid_reg && run_reg[s1_idx_reg] && asg_reg[s1_idx_reg])
        begin
            cnt_we = 1'b1;
            cnt_wa = s1_idx_reg;
            if (cnt_rd_reg == per_rd_reg)
            begin
                cnt_wd    = '0;
                mask_next = mask_reg | (MASK_W'(1) << s1_idx_reg);
            end
            else
            begin
                cnt_wd = cnt_rd_reg + INTERVAL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire
